[rtl/red_region_fill_persistence_unit_defines.svh]
// Assertion macros shared by the red region fill persistence unit.
`ifndef RED_REGION_FILL_PERSISTENCE_UNIT_DEFINES_SVH
`define RED_REGION_FILL_PERSISTENCE_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RRF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define RRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rrf_pkg.sv]
// Types, constants and register codes of the red region fill persistence unit.
package rrf_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned AREA_W      = 13;
  localparam int unsigned RED_TOTAL_W = 13;
  localparam int unsigned STREAK_W    = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 13;

  // Saturation limits and thresholds
  localparam int unsigned MAX_ROI_PIXELS = 4096;
  localparam int unsigned PERSIST_MAX    = 255;
  localparam int unsigned ASSEMBLED_MIN  = 3;

  // Fill test: FILL_NUM * count >= FILL_DEN * area
  localparam int unsigned FILL_NUM    = 2000;
  localparam int unsigned FILL_DEN    = 1401;
  localparam int unsigned FILL_W      = $clog2(FILL_NUM * MAX_ROI_PIXELS + 1);
  localparam int unsigned AREA_PROD_W = $clog2(FILL_DEN * (2 ** AREA_W - 1) + 1);

  localparam int unsigned QUEUE_DEPTH = 4;

  // Register reset values
  localparam logic [PIX_W-1:0]  RED_MIN_RST   = 8'd100;
  localparam logic [PIX_W-1:0]  GREEN_MAX_RST = 8'd100;
  localparam logic [PIX_W-1:0]  BLUE_MAX_RST  = 8'd100;
  localparam logic [PIX_W-1:0]  HUE_UPPER_RST = 8'd170;
  localparam logic [PIX_W-1:0]  HUE_LOWER_RST = 8'd10;
  localparam logic [PIX_W-1:0]  SAT_MIN_RST   = 8'd100;
  localparam logic [AREA_W-1:0] ROI_AREA_RST  = 13'd429;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_MIN,
    REG_GREEN_MAX,
    REG_BLUE_MAX,
    REG_HUE_UPPER,
    REG_HUE_LOWER,
    REG_SAT_MIN,
    REG_ROI_AREA
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             last;
  } pixel_t;

  typedef struct packed {
    logic                   is_red;
    logic                   frame_done;
    logic [RED_TOTAL_W-1:0] red_total;
    logic [STREAK_W-1:0]    streak;
    logic                   assembled;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  typedef struct packed {
    logic [PIX_W-1:0]  red_min;
    logic [PIX_W-1:0]  green_max;
    logic [PIX_W-1:0]  blue_max;
    logic [PIX_W-1:0]  hue_upper;
    logic [PIX_W-1:0]  hue_lower;
    logic [PIX_W-1:0]  sat_min;
    logic [AREA_W-1:0] roi_area;
  } cfg_regs_t;

  // One classified pixel on its way to the counting stage
  typedef struct packed {
    logic is_red;
    logic last;
  } q_entry_t;

endpackage

[rtl/rrf_stream_if.sv]
// Valid/ready channel with a typed payload.
interface rrf_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/rrf_front.sv]
// Pixel classifier: two-stage HSV red test feeding the classification queue.
module rrf_front import rrf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_regs_t cfg_i,
  rrf_stream_if.sink pix_i,
  output logic      push_valid_o,
  output q_entry_t  push_data_o,
  input  logic      push_ready_i
);

  // Stage 1: hue numerator, thresholds and saturation operands
  typedef struct packed {
    logic signed [17:0] x;
    logic signed [9:0]  d;
    logic signed [9:0]  tu;
    logic signed [9:0]  tl;
    logic [16:0]        sat_lhs;
    logic [8:0]         sat_t;
    logic [8:0]         mx2;
    logic               rgb_ok;
    logic               flat;
    logic               flat_hit;
    logic               dark;
    logic               last;
  } s1_t;

  // Stage 2: products ready for the compares
  typedef struct packed {
    logic signed [17:0] x;
    logic signed [19:0] pu;
    logic signed [19:0] pl;
    logic [16:0]        sat_lhs;
    logic [17:0]        sat_rhs;
    logic               rgb_ok;
    logic               flat;
    logic               flat_hit;
    logic               dark;
    logic               last;
  } s2_t;

  pixel_t             px;
  logic [PIX_W-1:0]   mx, mn, diff;
  logic signed [11:0] num;
  logic signed [17:0] num_w, x;
  logic               en1, en2;
  logic               s1_valid_q, s1_valid_d;
  logic               s2_valid_q, s2_valid_d;
  s1_t                s1_q, s1_d;
  s2_t                s2_q, s2_d;
  logic signed [19:0] x_ext;
  logic               hue_hit, sat_hit;

  assign px = pix_i.payload;

  // Advance each stage when the one after it has room
  assign en2         = !s2_valid_q || push_ready_i;
  assign en1         = !s1_valid_q || en2;
  assign pix_i.ready = en1;

  // Max, min and the sector numerator of the hue
  always_comb begin
    mx = px.red;
    if (px.green > mx) mx = px.green;
    if (px.blue > mx) mx = px.blue;
    mn = px.red;
    if (px.green < mn) mn = px.green;
    if (px.blue < mn) mn = px.blue;
    diff = mx - mn;
    if (mx == px.red) begin
      num = signed'(12'(px.green)) - signed'(12'(px.blue));
    end else if (mx == px.green) begin
      num = signed'(12'(px.blue)) - signed'(12'(px.red)) + signed'(12'({diff, 1'b0}));
    end else begin
      num = signed'(12'(px.red)) - signed'(12'(px.green)) + signed'(12'({diff, 2'b00}));
    end
    num_w = 18'(num);
    x     = num_w * 18'sd60 + signed'(18'(diff));
  end

  // Hue h = floor(x / 2diff), wrapped by 180 when negative: turn h > upper and
  // h < lower into compares of x against threshold times 2diff
  always_comb begin
    s1_d.x  = x;
    s1_d.d  = signed'({1'b0, diff, 1'b0});
    if (x[17]) begin
      s1_d.tu = signed'(10'(cfg_i.hue_upper)) - 10'sd179;
      s1_d.tl = signed'(10'(cfg_i.hue_lower)) - 10'sd180;
    end else begin
      s1_d.tu = signed'(10'(cfg_i.hue_upper)) + 10'sd1;
      s1_d.tl = signed'(10'(cfg_i.hue_lower));
    end
    // s > sat_min  <=>  510*diff + max >= (sat_min + 1) * 2*max
    s1_d.sat_lhs  = 17'(diff) * 17'd510 + 17'(mx);
    s1_d.sat_t    = 9'(cfg_i.sat_min) + 9'd1;
    s1_d.mx2      = {mx, 1'b0};
    s1_d.rgb_ok   = (px.red > cfg_i.red_min) && (px.green < cfg_i.green_max) &&
                    (px.blue < cfg_i.blue_max);
    s1_d.flat     = (diff == '0);
    s1_d.flat_hit = (cfg_i.hue_lower != '0);
    s1_d.dark     = (mx == '0);
    s1_d.last     = px.last;
  end

  // Multiply thresholds by the divisors
  always_comb begin
    s2_d.x        = s1_q.x;
    s2_d.pu       = 20'(s1_q.tu) * 20'(s1_q.d);
    s2_d.pl       = 20'(s1_q.tl) * 20'(s1_q.d);
    s2_d.sat_lhs  = s1_q.sat_lhs;
    s2_d.sat_rhs  = 18'(s1_q.sat_t) * 18'(s1_q.mx2);
    s2_d.rgb_ok   = s1_q.rgb_ok;
    s2_d.flat     = s1_q.flat;
    s2_d.flat_hit = s1_q.flat_hit;
    s2_d.dark     = s1_q.dark;
    s2_d.last     = s1_q.last;
  end

  assign s1_valid_d = en1 ? pix_i.valid : s1_valid_q;
  assign s2_valid_d = en2 ? s1_valid_q : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
  end

  // Final compares and the mask bit
  always_comb begin
    x_ext   = 20'(s2_q.x);
    hue_hit = s2_q.flat ? s2_q.flat_hit : ((x_ext >= s2_q.pu) || (x_ext < s2_q.pl));
    sat_hit = !s2_q.dark && (18'(s2_q.sat_lhs) >= s2_q.sat_rhs);
  end

  assign push_valid_o       = s2_valid_q;
  assign push_data_o.is_red = s2_q.rgb_ok && hue_hit && sat_hit;
  assign push_data_o.last   = s2_q.last;

endmodule

[rtl/rrf_queue.sv]
// Short queue of classified pixels between the classifier and the counter.
module rrf_queue import rrf_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  input  q_entry_t push_data_i,
  output logic     push_ready_o,
  output logic     pop_valid_o,
  output q_entry_t pop_data_o,
  input  logic     pop_ready_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  q_entry_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers with wrap and track occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    if (pop) rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    if (push && !pop) cnt_d = cnt_q + CntW'(1);
    else if (pop && !push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

[rtl/rrf_back.sv]
// Red pixel counter, fill test, persistence counter and result register.
module rrf_back import rrf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [AREA_W-1:0] roi_area_i,
  input  logic              pop_valid_i,
  input  q_entry_t          pop_data_i,
  output logic              pop_ready_o,
  rrf_stream_if.source      res_o
);

  logic [RED_TOTAL_W-1:0] count_q, count_d, count_new;
  logic [FILL_W-1:0]      fill_q, fill_d, fill_new;
  logic [STREAK_W-1:0]    persist_q, persist_d, persist_new;
  logic [AREA_PROD_W-1:0] area_prod_q, area_prod_d;
  logic                   res_valid_q, res_valid_d;
  result_t                res_q, res_d;
  logic                   take, inc, pass;

  // Take the next entry when the result register is free or draining
  assign pop_ready_o = !res_valid_q || res_o.ready;
  assign take        = pop_valid_i && pop_ready_o;

  // Follow the area register; the fill test reads the registered product
  assign area_prod_d = AREA_PROD_W'(roi_area_i) * AREA_PROD_W'(FILL_DEN);

  // Count red pixels with saturation, keeping FILL_NUM * count alongside
  always_comb begin
    inc       = pop_data_i.is_red && (count_q < RED_TOTAL_W'(MAX_ROI_PIXELS));
    count_new = count_q + RED_TOTAL_W'(inc);
    fill_new  = inc ? fill_q + FILL_W'(FILL_NUM) : fill_q;
    pass      = (AREA_PROD_W'(fill_new) >= area_prod_q);
    if (pass) begin
      persist_new = (persist_q < STREAK_W'(PERSIST_MAX)) ? persist_q + STREAK_W'(1)
                                                         : persist_q;
    end else begin
      persist_new = (persist_q != '0) ? persist_q - STREAK_W'(1) : persist_q;
    end
  end

  // Update state and form the result on each transfer from the queue
  always_comb begin
    count_d     = count_q;
    fill_d      = fill_q;
    persist_d   = persist_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_o.ready;
    if (take) begin
      res_valid_d      = 1'b1;
      res_d.is_red     = pop_data_i.is_red;
      res_d.frame_done = pop_data_i.last;
      if (pop_data_i.last) begin
        count_d         = '0;
        fill_d          = '0;
        persist_d       = persist_new;
        res_d.red_total = count_new;
        res_d.streak    = persist_new;
        res_d.assembled = (persist_new >= STREAK_W'(ASSEMBLED_MIN));
      end else begin
        count_d         = count_new;
        fill_d          = fill_new;
        res_d.red_total = '0;
        res_d.streak    = '0;
        res_d.assembled = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      fill_q      <= '0;
      persist_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      fill_q      <= fill_d;
      persist_q   <= persist_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    area_prod_q <= area_prod_d;
    res_q       <= res_d;
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

endmodule

[rtl/red_region_fill_persistence_unit.sv]
// Top level of the red region fill persistence unit.
// Usage:
//   pix_i takes one BGR pixel per transfer, last marking the final pixel of a
//   region. res_o gives one result per pixel: the red mask bit, and on the last
//   pixel the region's red count, the persistence streak and the assembled flag.
//   cfg_i writes the thresholds and the region area by index; it is always ready
//   and is to be written only while no pixel is in flight.
// Timing:
//   One pixel is taken every cycle unless res_o stalls. A result is formed from
//   its pixel through two classifier stages (hue and saturation compares through
//   small multipliers), a queue write, then the counter stage that fills the
//   output register. The counter retires one pixel per cycle unless res_o stalls.
// Reset:
//   Registers return to their defaults, counts and the streak to zero, and the
//   pipeline, queue and output register are emptied.
// Stall:
//   While res_o is not ready the result holds; the queue and the classifier
//   stages fill and then pix_i.ready drops until the receiver takes results.
`include "red_region_fill_persistence_unit_defines.svh"
module red_region_fill_persistence_unit import rrf_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rrf_stream_if.sink   pix_i,
  rrf_stream_if.sink   cfg_i,
  rrf_stream_if.source res_o
);

  cfg_regs_t cfg_q, cfg_d;
  cfg_write_t wr;
  logic      q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  q_entry_t  q_push_data, q_pop_data;

  // Register writes; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.payload;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(wr.index))
        REG_RED_MIN:   cfg_d.red_min   = wr.data[PIX_W-1:0];
        REG_GREEN_MAX: cfg_d.green_max = wr.data[PIX_W-1:0];
        REG_BLUE_MAX:  cfg_d.blue_max  = wr.data[PIX_W-1:0];
        REG_HUE_UPPER: cfg_d.hue_upper = wr.data[PIX_W-1:0];
        REG_HUE_LOWER: cfg_d.hue_lower = wr.data[PIX_W-1:0];
        REG_SAT_MIN:   cfg_d.sat_min   = wr.data[PIX_W-1:0];
        REG_ROI_AREA:  cfg_d.roi_area  = wr.data[AREA_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_min   <= RED_MIN_RST;
      cfg_q.green_max <= GREEN_MAX_RST;
      cfg_q.blue_max  <= BLUE_MAX_RST;
      cfg_q.hue_upper <= HUE_UPPER_RST;
      cfg_q.hue_lower <= HUE_LOWER_RST;
      cfg_q.sat_min   <= SAT_MIN_RST;
      cfg_q.roi_area  <= ROI_AREA_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rrf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pix_i        (pix_i),
    .push_valid_o (q_push_valid),
    .push_data_o  (q_push_data),
    .push_ready_i (q_push_ready)
  );

  rrf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_data_i  (q_push_data),
    .push_ready_o (q_push_ready),
    .pop_valid_o  (q_pop_valid),
    .pop_data_o   (q_pop_data),
    .pop_ready_i  (q_pop_ready)
  );

  rrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .roi_area_i  (cfg_q.roi_area),
    .pop_valid_i (q_pop_valid),
    .pop_data_i  (q_pop_data),
    .pop_ready_o (q_pop_ready),
    .res_o       (res_o)
  );

  // Checks
  `RRF_ASSERT_NEXT(a_pop_fills_result, clk_i, rst_ni, q_pop_valid && q_pop_ready, res_o.valid, "queue transfer did not produce a result")
  `RRF_ASSERT_IMPLIES(a_stall_from_queue, clk_i, rst_ni, !pix_i.ready, q_push_valid && !q_push_ready, "pixel input stalled without a full queue")
  `RRF_ASSERT_IMPLIES(a_assembled_streak, clk_i, rst_ni, res_o.valid && res_o.payload.frame_done, res_o.payload.assembled == (res_o.payload.streak >= STREAK_W'(ASSEMBLED_MIN)), "assembled flag disagrees with streak")

endmodule
